// File: rtl/assert_macros.svh
// assertion macros shared by the concealer modules
// needs a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, off during reset
`define AFRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define AFRC_ASSERT_IMP(name, ante, cons, msg) \
  `AFRC_ASSERT(name, (ante) |-> (cons), msg)

// next-cycle implication
`define AFRC_ASSERT_NXT(name, ante, cons, msg) \
  `AFRC_ASSERT(name, (ante) |=> (cons), msg)

`endif

// File: rtl/afrc_pkg.sv
// types, constants and arithmetic helpers of the fade-repeat concealer
// no dependencies
package afrc_pkg;

  localparam int STORE_SAMPLES_DEF = 2048;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int FRAMES_W = 12;
  localparam int CHANS_W  = 4;
  localparam int REPS_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CAP_PROD_W = FRAMES_W + CHANS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN         = 2'd3;

  // register reset values
  localparam logic [FRAMES_W-1:0] FRAMES_RST        = 12'd1024;
  localparam logic [CHANS_W-1:0]  CHANNEL_COUNT_RST = 4'd2;
  localparam logic [REPS_W-1:0]   REPEAT_LIMIT_RST  = 8'd3;
  localparam logic [GAIN_W-1:0]   ATTEN_RST         = 16'd16384;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [GAIN_W-1:0]   GAIN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
    logic [COUNT_W-1:0]         underrun_count;
  } result_t;

  // sideband that travels with a store read into the scaling stage
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic               silent;
    logic               last;
    logic [COUNT_W-1:0] count;
  } stage_t;

  // sample times Q1.15 gain, truncated toward zero, clamped to int16
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [GAIN_W-1:0]          g
  );
    logic [SAMPLE_W-1:0]          mag;
    logic [SAMPLE_W+GAIN_W-1:0]   prod;
    logic [SAMPLE_W:0]            m;
    logic signed [SAMPLE_W-1:0]   res;
    mag  = s[SAMPLE_W-1] ? (~s + 16'd1) : s;
    prod = 32'(mag) * 32'(g);
    m    = prod[SAMPLE_W+GAIN_W-1:15];
    if (s[SAMPLE_W-1]) begin
      res = (m >= 17'd32768) ? SAMPLE_MIN : 16'(17'd0 - m);
    end else begin
      res = (m > 17'd32767) ? SAMPLE_MAX : m[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // gain times attenuation in Q1.15, saturated at full scale
  function automatic logic [GAIN_W-1:0] gain_mul(
    input logic [GAIN_W-1:0] g,
    input logic [GAIN_W-1:0] a
  );
    logic [2*GAIN_W-1:0] prod;
    logic [GAIN_W:0]     p;
    prod = 32'(g) * 32'(a);
    p    = prod[2*GAIN_W-1:15];
    return p[GAIN_W] ? GAIN_MAX : p[GAIN_W-1:0];
  endfunction

endpackage

// File: rtl/afrc_stream_if.sv
// valid/ready channel with a typed payload
// payload types come from afrc_pkg at the instance
interface afrc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/afrc_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module afrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: rtl/afrc_ctrl.sv
// config registers, buffer and request positions, repeat/gain state
// uses afrc_pkg and assert_macros.svh; drives the store and the scaling stage
`include "assert_macros.svh"

module afrc_ctrl #(
  parameter int STORE_SAMPLES = afrc_pkg::STORE_SAMPLES_DEF,
  localparam int ADDR_W = $clog2(STORE_SAMPLES),
  localparam int POS_W  = $clog2(STORE_SAMPLES + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [afrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afrc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  input  afrc_pkg::item_t                    in_item,
  output logic                               in_ready,
  input  logic                               advance,
  output logic                               wr_en,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic [afrc_pkg::SAMPLE_W-1:0]      wr_data,
  output logic                               rd_en,
  output logic [ADDR_W-1:0]                  rd_addr,
  output logic                               s1_valid,
  output afrc_pkg::stage_t                   s1_info
);
  logic [afrc_pkg::FRAMES_W-1:0] frame_count;
  logic [afrc_pkg::CHANS_W-1:0]  channel_count;
  logic [afrc_pkg::REPS_W-1:0]   repeat_limit;
  logic [afrc_pkg::GAIN_W-1:0]   atten_gain;

  logic [POS_W-1:0]              stored_length, stored_length_next;
  logic [POS_W-1:0]              write_pos, write_pos_next;
  logic [POS_W-1:0]              read_pos, read_pos_next;
  logic [afrc_pkg::REPS_W-1:0]   repeats_done, repeats_done_next;
  logic [afrc_pkg::GAIN_W-1:0]   current_gain, current_gain_next;
  logic [afrc_pkg::COUNT_W-1:0]  request_count, request_count_next;
  logic                          s1_valid_next;

  logic [afrc_pkg::CAP_PROD_W-1:0] cap_prod;
  logic [POS_W-1:0]                cap;
  logic                            in_fire;
  logic                            store_ok;
  logic                            emit;
  logic                            live;
  logic [POS_W-1:0]                wp_after;

  // capacity in samples, saturated at the store depth
  always_comb begin
    cap_prod = afrc_pkg::CAP_PROD_W'(frame_count) * afrc_pkg::CAP_PROD_W'(channel_count);
    cap = (32'(cap_prod) > 32'(STORE_SAMPLES)) ? POS_W'(STORE_SAMPLES) : POS_W'(cap_prod);
  end

  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;
  assign store_ok = write_pos < cap;
  assign emit     = read_pos < cap;
  assign live     = (repeats_done < repeat_limit) && (read_pos < stored_length);
  assign wp_after = store_ok ? write_pos + POS_W'(1) : write_pos;

  assign wr_en   = in_fire && !in_item.mode && store_ok;
  assign wr_addr = write_pos[ADDR_W-1:0];
  assign wr_data = in_item.sample_in;
  assign rd_en   = in_fire && in_item.mode;
  assign rd_addr = read_pos[ADDR_W-1:0];

  always_comb begin
    stored_length_next = stored_length;
    write_pos_next     = write_pos;
    read_pos_next      = read_pos;
    repeats_done_next  = repeats_done;
    current_gain_next  = current_gain;
    request_count_next = request_count;
    s1_valid_next      = advance ? 1'b0 : s1_valid;
    if (in_fire) begin
      if (!in_item.mode) begin
        write_pos_next = wp_after;
        if (in_item.last_in) begin
          stored_length_next = wp_after;
          write_pos_next     = '0;
          repeats_done_next  = '0;
          current_gain_next  = atten_gain;
        end
      end else begin
        s1_valid_next = emit;
        if (emit) begin
          read_pos_next = read_pos + POS_W'(1);
        end
        if (in_item.last_in) begin
          read_pos_next      = '0;
          request_count_next = request_count + 32'd1;
          if (repeats_done < repeat_limit) begin
            repeats_done_next = repeats_done + 8'd1;
            current_gain_next = afrc_pkg::gain_mul(current_gain, atten_gain);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= afrc_pkg::FRAMES_RST;
      channel_count <= afrc_pkg::CHANNEL_COUNT_RST;
      repeat_limit  <= afrc_pkg::REPEAT_LIMIT_RST;
      atten_gain    <= afrc_pkg::ATTEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        afrc_pkg::REG_FRAMES:        frame_count   <= cfg_data[afrc_pkg::FRAMES_W-1:0];
        afrc_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[afrc_pkg::CHANS_W-1:0];
        afrc_pkg::REG_REPEAT_LIMIT:  repeat_limit  <= cfg_data[afrc_pkg::REPS_W-1:0];
        afrc_pkg::REG_ATTEN:         atten_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_length <= '0;
      write_pos     <= '0;
      read_pos      <= '0;
      repeats_done  <= '0;
      current_gain  <= afrc_pkg::ATTEN_RST;
      request_count <= '0;
      s1_valid      <= 1'b0;
    end else begin
      stored_length <= stored_length_next;
      write_pos     <= write_pos_next;
      read_pos      <= read_pos_next;
      repeats_done  <= repeats_done_next;
      current_gain  <= current_gain_next;
      request_count <= request_count_next;
      s1_valid      <= s1_valid_next;
    end
  end

  // sideband captured with the store read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_info.gain   <= current_gain;
      s1_info.silent <= !live;
      s1_info.last   <= in_item.last_in;
      s1_info.count  <= request_count + 32'd1;
    end
  end

  `AFRC_ASSERT_IMP(a_stall_only_when_held, !in_ready, s1_valid, "input stalled with empty stage")
  `AFRC_ASSERT(a_write_pos_range, write_pos <= POS_W'(STORE_SAMPLES), "write position past store")
  `AFRC_ASSERT(a_length_range, stored_length <= POS_W'(STORE_SAMPLES), "stored length past store")
  `AFRC_ASSERT_NXT(a_past_length_silent, in_fire && in_item.mode && (read_pos >= stored_length), s1_info.silent, "read past stored data not silenced")
endmodule

// File: rtl/afrc_scale.sv
// scaling stage: store data times gain, clamp, result register
// uses afrc_pkg and assert_macros.svh; fed by afrc_ctrl and the store
`include "assert_macros.svh"

module afrc_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  input  afrc_pkg::stage_t              s1_info,
  input  logic [afrc_pkg::SAMPLE_W-1:0] rd_data,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output afrc_pkg::result_t             out_item
);
  afrc_pkg::result_t out_next;

  assign advance = !out_valid || out_ready;

  always_comb begin
    out_next.sample_out     = s1_info.silent ? '0
                            : afrc_pkg::scale_sample(rd_data, s1_info.gain);
    out_next.last_out       = s1_info.last;
    out_next.underrun_count = s1_info.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_item <= out_next;
    end
  end

  `AFRC_ASSERT_IMP(a_stage_lands, $past(s1_valid && advance), out_valid, "stage word lost")
  `AFRC_ASSERT_NXT(a_silent_zero, s1_valid && advance && s1_info.silent, out_item.sample_out == '0, "silent word not zero")
  `AFRC_ASSERT_NXT(a_held_word_stable, out_valid && !out_ready, out_valid && $stable(out_item), "held word changed")
endmodule

// File: rtl/audio_fade_repeat_concealer.sv
// top level of the fade-repeat concealer: control, sample store, scaling stage
// uses afrc_pkg, afrc_stream_if, afrc_ram, afrc_ctrl, afrc_scale
//
//  channel  | kind        | payload
//  ---------+-------------+------------------------------------------
//  items    | valid/ready | mode, sample_in, last_in
//  results  | valid/ready | sample_out, last_out, underrun_count
//  cfg      | write only  | cfg_wr_en, cfg_index, cfg_data
//
// one item per cycle while items.ready is high; only a request (mode set) within capacity
// yields a result word: store read register, then the multiply into the result register
// sync reset clears positions and counts, loads the register defaults; the store is not cleared
// items stall only while the scaling stage and the result register are both full
// and the result word is not taken
module audio_fade_repeat_concealer #(
  parameter int STORE_SAMPLES = afrc_pkg::STORE_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [afrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afrc_pkg::CFG_W-1:0]     cfg_data,
  afrc_stream_if.sink                    items,
  afrc_stream_if.source                  results
);
  localparam int ADDR_W = $clog2(STORE_SAMPLES);

  logic                          advance;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [afrc_pkg::SAMPLE_W-1:0] wr_data;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [afrc_pkg::SAMPLE_W-1:0] rd_data;
  logic                          s1_valid;
  afrc_pkg::stage_t              s1_info;
  afrc_pkg::item_t               in_item;
  afrc_pkg::result_t             out_item;

  assign in_item      = items.data;
  assign results.data = out_item;

  afrc_ctrl #(
    .STORE_SAMPLES(STORE_SAMPLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (items.valid),
    .in_item  (in_item),
    .in_ready (items.ready),
    .advance  (advance),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_info  (s1_info)
  );

  afrc_ram #(
    .WIDTH(afrc_pkg::SAMPLE_W),
    .DEPTH(STORE_SAMPLES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  afrc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .rd_data  (rd_data),
    .advance  (advance),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .out_item (out_item)
  );
endmodule
